// ===== src/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared payload types, stage records and arithmetic constants.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  typedef struct packed {
    logic [15:0] hue_deg;
    logic [7:0]  sat_pct;
    logic [7:0]  val_pct;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } rgb_t;

  // Hue sectors of 60 degrees each, starting at red.
  typedef enum logic [2:0] {
    SEC_RED,
    SEC_YELLOW,
    SEC_GREEN,
    SEC_CYAN,
    SEC_BLUE,
    SEC_MAGENTA
  } sector_t;

  localparam int PCT_W   = 7;   // clamped percent, 0..100
  localparam int HUE_W   = 9;   // wrapped hue, 0..359
  localparam int REM_W   = 6;   // remainder within a sector, 0..59
  localparam int FRAC_W  = 13;  // scaled fraction, 0..6000
  localparam int NUM_W   = 20;  // level numerator, 0..600000
  localparam int BIAS_W  = 28;  // numerator * 255 plus rounding bias
  localparam int DIVN_W  = 22;  // biased value after the shift by 64
  localparam int RECIP_W = 23;
  localparam int PROD_W  = DIVN_W + RECIP_W;

  localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
  localparam logic [HUE_W-1:0]   HUE_TURN   = 9'd360;
  localparam logic [REM_W-1:0]   HUE_SECTOR = 6'd60;
  localparam logic [FRAC_W-1:0]  FRAC_FULL  = 13'd6000;

  // floor(hue / 360) is estimated as (hue * 46603) >> 24, which is low by
  // at most one for any 16-bit hue.
  localparam logic [15:0] WRAP_RECIP = 16'd46603;
  localparam int          WRAP_SHIFT = 24;

  // level = floor((num * 255 + 300000) / 600000). The divisor is 64 * 9375;
  // the quotient by 9375 is exact through the reciprocal below.
  localparam logic [BIAS_W-1:0]  ROUND_BIAS  = 28'd300000;
  localparam int                 ROUND_PRE   = 6;
  localparam logic [RECIP_W-1:0] ROUND_RECIP = 23'd7330078;
  localparam int                 ROUND_SHIFT = 36;

  // Lanes of the level numerators.
  localparam int LANE_P  = 0;
  localparam int LANE_Q  = 1;
  localparam int LANE_T  = 2;
  localparam int LANE_V  = 3;
  localparam int LANE_CNT = 4;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [7:0]       level_t;

  typedef struct packed {
    logic                valid;
    sector_t             sector;
    logic                grey;
    logic [PCT_W-1:0]    sat;
    logic [PCT_W-1:0]    val;
    logic [REM_W-1:0]    rem;
  } hue_info_t;

  typedef struct packed {
    logic                valid;
    sector_t             sector;
    logic                grey;
    num_t [LANE_CNT-1:0] num;
  } num_info_t;

  typedef struct packed {
    logic                  valid;
    sector_t               sector;
    logic                  grey;
    level_t [LANE_CNT-1:0] lvl;
  } lvl_info_t;

endpackage

// ===== src/hsv_to_rgb_converter_top.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Pipelined conversion of one HSV pixel per clock into 8-bit RGB levels.
// ----------------------------------------------------------------------------
// One pixel is taken in every clock in which start is high; busy never rises,
// since nothing in the pipeline can stall. The matching RGB pixel appears on
// rgb with done high, in order, once it has passed the eight register stages,
// and is shown for one cycle only. The eight register stages are:
// hue clamp and reciprocal product, hue wrap, sector split,
// fractions, value products, scaling by 255, the exact rounding divide, and
// the channel routing register.
module hsv_to_rgb_converter_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  hsv2rgb_pkg::hsv_t hsv,
  output logic              done,
  output hsv2rgb_pkg::rgb_t rgb
);

  hsv2rgb_pkg::hue_info_t info;
  hsv2rgb_pkg::num_info_t nums;
  hsv2rgb_pkg::lvl_info_t lvls;
  hsv2rgb_pkg::rgb_t      rgb_next;

  logic accept;
  hsv2rgb_pkg::level_t lp;
  hsv2rgb_pkg::level_t lq;
  hsv2rgb_pkg::level_t lt;
  hsv2rgb_pkg::level_t lv;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  hsv2rgb_hue_unit u_hue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .hsv      (hsv),
    .info     (info)
  );

  hsv2rgb_num_unit u_num (
    .clk  (clk),
    .rst  (rst),
    .info (info),
    .nums (nums)
  );

  hsv2rgb_round_unit u_round (
    .clk  (clk),
    .rst  (rst),
    .nums (nums),
    .lvls (lvls)
  );

  assign lp = lvls.lvl[hsv2rgb_pkg::LANE_P];
  assign lq = lvls.lvl[hsv2rgb_pkg::LANE_Q];
  assign lt = lvls.lvl[hsv2rgb_pkg::LANE_T];
  assign lv = lvls.lvl[hsv2rgb_pkg::LANE_V];

  // A grey pixel rounds v * 6000 exactly as (v * 255 + 50) / 100, so the
  // v level serves every channel.
  always_comb begin
    rgb_next = '{red_level: lv, green_level: lp, blue_level: lq};
    if (lvls.grey) begin
      rgb_next = '{red_level: lv, green_level: lv, blue_level: lv};
    end else begin
      case (lvls.sector)
        hsv2rgb_pkg::SEC_RED:
          rgb_next = '{red_level: lv, green_level: lt, blue_level: lp};
        hsv2rgb_pkg::SEC_YELLOW:
          rgb_next = '{red_level: lq, green_level: lv, blue_level: lp};
        hsv2rgb_pkg::SEC_GREEN:
          rgb_next = '{red_level: lp, green_level: lv, blue_level: lt};
        hsv2rgb_pkg::SEC_CYAN:
          rgb_next = '{red_level: lp, green_level: lq, blue_level: lv};
        hsv2rgb_pkg::SEC_BLUE:
          rgb_next = '{red_level: lt, green_level: lp, blue_level: lv};
        default:
          rgb_next = '{red_level: lv, green_level: lp, blue_level: lq};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    done <= lvls.valid;
    rgb  <= rgb_next;
    if (rst) begin
      done <= 1'b0;
    end
  end

endmodule

// ===== src/hsv2rgb_hue_unit.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB hue unit
// Three stages: clamp and reciprocal product, hue wrap, sector split.
// ----------------------------------------------------------------------------
module hsv2rgb_hue_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  hsv2rgb_pkg::hsv_t      hsv,
  output hsv2rgb_pkg::hue_info_t info
);

  // Stage 1
  logic                          valid1;
  logic [31:0]                   prod1;
  logic [15:0]                   hue1;
  logic [hsv2rgb_pkg::PCT_W-1:0] sat1;
  logic [hsv2rgb_pkg::PCT_W-1:0] val1;
  logic                          grey1;

  // Stage 2
  logic                          valid2;
  logic [hsv2rgb_pkg::HUE_W-1:0] hue2;
  logic [hsv2rgb_pkg::PCT_W-1:0] sat2;
  logic [hsv2rgb_pkg::PCT_W-1:0] val2;
  logic                          grey2;

  logic [7:0]  quo;
  logic [16:0] diff;
  logic [9:0]  wrap;
  logic [hsv2rgb_pkg::HUE_W-1:0] hue2_next;

  hsv2rgb_pkg::sector_t          sector_next;
  logic [hsv2rgb_pkg::HUE_W-1:0] base;
  logic [hsv2rgb_pkg::HUE_W-1:0] rem_wide;

  always_ff @(posedge clk) begin
    valid1 <= in_valid;
    prod1  <= 32'(hsv.hue_deg) * 32'(hsv2rgb_pkg::WRAP_RECIP);
    hue1   <= hsv.hue_deg;
    sat1   <= (hsv.sat_pct > 8'(hsv2rgb_pkg::PCT_FULL)) ? hsv2rgb_pkg::PCT_FULL
                                                         : hsv.sat_pct[6:0];
    val1   <= (hsv.val_pct > 8'(hsv2rgb_pkg::PCT_FULL)) ? hsv2rgb_pkg::PCT_FULL
                                                         : hsv.val_pct[6:0];
    grey1  <= (hsv.sat_pct == 8'd0);
    if (rst) begin
      valid1 <= 1'b0;
    end
  end

  // The estimated quotient is at most one low, so one correction suffices.
  always_comb begin
    quo  = prod1[hsv2rgb_pkg::WRAP_SHIFT +: 8];
    diff = {1'b0, hue1} - 17'(quo) * 17'(hsv2rgb_pkg::HUE_TURN);
    wrap = diff[9:0];
    if (wrap >= 10'(hsv2rgb_pkg::HUE_TURN)) begin
      hue2_next = 9'(wrap - 10'(hsv2rgb_pkg::HUE_TURN));
    end else begin
      hue2_next = wrap[8:0];
    end
  end

  always_ff @(posedge clk) begin
    valid2 <= valid1;
    hue2   <= hue2_next;
    sat2   <= sat1;
    val2   <= val1;
    grey2  <= grey1;
    if (rst) begin
      valid2 <= 1'b0;
    end
  end

  always_comb begin
    if (hue2 >= 9'd300) begin
      sector_next = hsv2rgb_pkg::SEC_MAGENTA;
      base        = 9'd300;
    end else if (hue2 >= 9'd240) begin
      sector_next = hsv2rgb_pkg::SEC_BLUE;
      base        = 9'd240;
    end else if (hue2 >= 9'd180) begin
      sector_next = hsv2rgb_pkg::SEC_CYAN;
      base        = 9'd180;
    end else if (hue2 >= 9'd120) begin
      sector_next = hsv2rgb_pkg::SEC_GREEN;
      base        = 9'd120;
    end else if (hue2 >= 9'(hsv2rgb_pkg::HUE_SECTOR)) begin
      sector_next = hsv2rgb_pkg::SEC_YELLOW;
      base        = 9'(hsv2rgb_pkg::HUE_SECTOR);
    end else begin
      sector_next = hsv2rgb_pkg::SEC_RED;
      base        = 9'd0;
    end
    rem_wide = hue2 - base;
  end

  always_ff @(posedge clk) begin
    info.valid  <= valid2;
    info.sector <= sector_next;
    info.grey   <= grey2;
    info.sat    <= sat2;
    info.val    <= val2;
    info.rem    <= rem_wide[hsv2rgb_pkg::REM_W-1:0];
    if (rst) begin
      info.valid <= 1'b0;
    end
  end

endmodule

// ===== src/hsv2rgb_num_unit.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB numerator unit
// Two stages: scaled fractions, then the value products for p, q, t and v.
// ----------------------------------------------------------------------------
module hsv2rgb_num_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  hsv2rgb_pkg::hue_info_t info,
  output hsv2rgb_pkg::num_info_t nums
);

  logic                           valid4;
  hsv2rgb_pkg::sector_t           sector4;
  logic                           grey4;
  logic [hsv2rgb_pkg::PCT_W-1:0]  val4;
  logic [hsv2rgb_pkg::FRAC_W-1:0] p_frac;
  logic [hsv2rgb_pkg::FRAC_W-1:0] sr;
  logic [hsv2rgb_pkg::FRAC_W-1:0] st;

  logic [hsv2rgb_pkg::FRAC_W-1:0] q_frac;
  logic [hsv2rgb_pkg::FRAC_W-1:0] t_frac;

  always_ff @(posedge clk) begin
    valid4  <= info.valid;
    sector4 <= info.sector;
    grey4   <= info.grey;
    val4    <= info.val;
    p_frac  <= 13'(hsv2rgb_pkg::PCT_FULL - info.sat) * 13'(hsv2rgb_pkg::HUE_SECTOR);
    sr      <= 13'(info.sat) * 13'(info.rem);
    st      <= 13'(info.sat) * 13'(hsv2rgb_pkg::HUE_SECTOR - info.rem);
    if (rst) begin
      valid4 <= 1'b0;
    end
  end

  // With saturation at most 100, s * r stays at or below 6000.
  assign q_frac = hsv2rgb_pkg::FRAC_FULL - sr;
  assign t_frac = hsv2rgb_pkg::FRAC_FULL - st;

  always_ff @(posedge clk) begin
    nums.valid  <= valid4;
    nums.sector <= sector4;
    nums.grey   <= grey4;
    nums.num[hsv2rgb_pkg::LANE_P] <= 20'(val4) * 20'(p_frac);
    nums.num[hsv2rgb_pkg::LANE_Q] <= 20'(val4) * 20'(q_frac);
    nums.num[hsv2rgb_pkg::LANE_T] <= 20'(val4) * 20'(t_frac);
    nums.num[hsv2rgb_pkg::LANE_V] <= 20'(val4) * 20'(hsv2rgb_pkg::FRAC_FULL);
    if (rst) begin
      nums.valid <= 1'b0;
    end
  end

endmodule

// ===== src/hsv2rgb_round_unit.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB rounding unit
// Two stages: scale by 255 with rounding bias, then exact constant divide.
// ----------------------------------------------------------------------------
module hsv2rgb_round_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  hsv2rgb_pkg::num_info_t nums,
  output hsv2rgb_pkg::lvl_info_t lvls
);

  logic                 valid6;
  hsv2rgb_pkg::sector_t sector6;
  logic                 grey6;
  logic [hsv2rgb_pkg::DIVN_W-1:0] divn [hsv2rgb_pkg::LANE_CNT];

  always_ff @(posedge clk) begin
    valid6  <= nums.valid;
    sector6 <= nums.sector;
    grey6   <= nums.grey;
    if (rst) begin
      valid6 <= 1'b0;
    end
  end

  for (genvar i = 0; i < hsv2rgb_pkg::LANE_CNT; i++) begin : g_lane
    logic [hsv2rgb_pkg::BIAS_W-1:0] biased;
    logic [hsv2rgb_pkg::PROD_W-1:0] prod;

    // num * 255 as num * 256 - num.
    assign biased = {nums.num[i], 8'd0} - hsv2rgb_pkg::BIAS_W'(nums.num[i])
                    + hsv2rgb_pkg::ROUND_BIAS;
    assign prod   = hsv2rgb_pkg::PROD_W'(divn[i])
                    * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::ROUND_RECIP);

    always_ff @(posedge clk) begin
      divn[i]     <= biased[hsv2rgb_pkg::BIAS_W-1:hsv2rgb_pkg::ROUND_PRE];
      lvls.lvl[i] <= prod[hsv2rgb_pkg::ROUND_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    lvls.valid  <= valid6;
    lvls.sector <= sector6;
    lvls.grey   <= grey6;
    if (rst) begin
      lvls.valid <= 1'b0;
    end
  end

endmodule
